// ===== design/swm_pkg.sv =====
// Shared types and constants for the sliding window median unit.
// No dependencies; used by swm_ram and sliding_window_median_unit.
`default_nettype none
package swm_pkg;
	// per-cycle control of one RAM port pair
	typedef struct packed {
		logic we;
		logic re;
	} ram_ctl_t;

	localparam int unsigned LEN_W     = 7;
	localparam logic [6:0]  LEN_RESET = 7'd64;
endpackage
`default_nettype wire

// ===== design/swm_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
// Depends on swm_pkg for the port control struct.
`default_nettype none
module swm_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned DW    = 16,
	parameter int unsigned AW    = 6
) (
	input  wire logic              clk,
	input  wire swm_pkg::ram_ctl_t ctl,
	input  wire logic [AW-1:0]     waddr,
	input  wire logic [DW-1:0]     wdata,
	input  wire logic [AW-1:0]     raddr,
	output logic      [DW-1:0]     rdata
);
	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/sliding_window_median_unit.sv =====
// Sliding window median: top level with sequencer, ring and sorted RAMs.
// Depends on swm_pkg and swm_ram.
//
// channel | dir | handshake                    | contents
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | tdata: sample
// m_axis  | out | m_axis_tvalid/m_axis_tready  | tdata: median,min,max,sum,count; tuser: full
// cfg     | in  | cfg_valid/cfg_ready          | cfg_data: window_length
//
// A word passes these steps from accept to accept, paced by the single read port of
// the sorted RAM: ring read of the evicted sample, a read and a check per entry for
// the removal scan, the insertion shift, the median/min/max reads, and loading the
// result.
// Reset clears count, write slot and sum; both RAMs are left as is.
// A finished result waits in the output register while the next word is taken;
// the sequencer stalls in its last state only while an older result is unread.
// A length write is taken only between words and wins over a waiting sample.
`default_nettype none
module sliding_window_median_unit #(
	parameter int unsigned MAX_WINDOW  = 64,
	parameter int unsigned SAMPLE_BITS = 16,
	localparam int unsigned SB    = SAMPLE_BITS,
	localparam int unsigned AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
	localparam int unsigned CW    = $clog2(MAX_WINDOW + 1),
	localparam int unsigned SUMW  = SB + AW,
	localparam int unsigned IN_W  = ((SB + 7) / 8) * 8,
	localparam int unsigned RAW_W = 3 * SB + SUMW + CW,
	localparam int unsigned OUT_W = ((RAW_W + 7) / 8) * 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire logic [IN_W-1:0]      s_axis_tdata,  // [SB-1:0] sample
	output logic                      m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	// median, minimum, maximum, sum, count from bit 0 up
	output logic [OUT_W-1:0]          m_axis_tdata,
	output logic [0:0]                m_axis_tuser,  // window_full
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [swm_pkg::LEN_W-1:0] cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_OLD, ST_RM_RD, ST_RM_CHK, ST_INS_START,
		ST_INS_RD, ST_INS_CHK, ST_INS_LAST, ST_FIN, ST_OUT
	} state_t;

	state_t                    state_q;
	logic [swm_pkg::LEN_W-1:0] len_q;
	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             idx_q;
	logic [2:0]                ph_q;
	logic                      found_q;
	logic signed [SUMW-1:0]    sum_q;
	logic [SB-1:0]             v_q, old_q, hi_q, lo_q, min_q, max_q;
	logic                      ovalid_q;
	logic [OUT_W-1:0]          odata_q;
	logic                      ofull_q;

	logic [CW-1:0]     len_eff;
	logic [AW-1:0]     wp_next;
	logic [CW-1:0]     wp_inc;
	logic [SB-1:0]     sample;
	logic              in_acc;
	logic              full_now;
	logic              out_load;

	swm_pkg::ram_ctl_t ring_ctl, sort_ctl;
	logic [AW-1:0]     ring_waddr, sort_waddr, sort_raddr;
	logic [SB-1:0]     ring_wdata, sort_wdata, ring_rdata, sort_rdata;

	logic signed [SB:0] pair_sum, pair_adj;
	logic [SB-1:0]      median;
	logic [CW-1:0]      half;

	assign sample   = s_axis_tdata[SB-1:0];
	assign in_acc   = s_axis_tvalid && s_axis_tready;
	// a pending length write goes first
	assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == ST_IDLE);
	assign full_now = (cnt_q >= len_eff);
	assign half     = cnt_q >> 1;
	assign out_load = (state_q == ST_OUT) && (!ovalid_q || m_axis_tready);

	always_comb begin
		if (len_q == '0) begin
			len_eff = CW'(1);
		end else if (32'(len_q) > MAX_WINDOW) begin
			len_eff = CW'(MAX_WINDOW);
		end else begin
			len_eff = CW'(len_q);
		end
	end

	// ring slot advance, wrapping at the effective length
	always_comb begin
		wp_inc  = CW'(wp_q) + CW'(1);
		wp_next = (wp_inc >= len_eff) ? '0 : wp_inc[AW-1:0];
	end

	// ring RAM: read the slot being evicted, write the new sample
	always_comb begin
		ring_ctl.re = in_acc && full_now;
		ring_ctl.we = (in_acc && !full_now) || (state_q == ST_OLD);
		ring_waddr  = wp_q;
		ring_wdata  = (state_q == ST_OLD) ? v_q : sample;
	end

	// sorted RAM port control
	always_comb begin
		sort_ctl   = '{we: 1'b0, re: 1'b0};
		sort_raddr = idx_q[AW-1:0];
		sort_waddr = idx_q[AW-1:0];
		sort_wdata = v_q;
		case (state_q)
			ST_RM_RD, ST_INS_RD: begin
				sort_ctl.re = 1'b1;
			end
			ST_RM_CHK: begin
				// shift entries above the removed one down by one
				sort_ctl.we = found_q;
				sort_waddr  = AW'(idx_q - CW'(1));
				sort_wdata  = sort_rdata;
			end
			ST_INS_START: begin
				sort_ctl.we = (cnt_q == '0);
				sort_waddr  = '0;
			end
			ST_INS_CHK: begin
				sort_ctl.we = 1'b1;
				sort_waddr  = AW'(idx_q + CW'(1));
				sort_wdata  = ($signed(sort_rdata) > $signed(v_q)) ? sort_rdata : v_q;
			end
			ST_INS_LAST: begin
				sort_ctl.we = 1'b1;
				sort_waddr  = '0;
			end
			ST_FIN: begin
				sort_ctl.re = (ph_q < 3'd4);
				case (ph_q)
					3'd0: sort_raddr = half[AW-1:0];
					3'd1: sort_raddr = cnt_q[0] ? half[AW-1:0] : AW'(half - CW'(1));
					3'd2: sort_raddr = '0;
					default: sort_raddr = AW'(cnt_q - CW'(1));
				endcase
			end
			default: begin
				sort_ctl = '{we: 1'b0, re: 1'b0};
			end
		endcase
	end

	swm_ram #(.DEPTH(MAX_WINDOW), .DW(SB), .AW(AW)) u_ring (
		.clk, .ctl(ring_ctl), .waddr(ring_waddr), .wdata(ring_wdata),
		.raddr(wp_q), .rdata(ring_rdata)
	);

	swm_ram #(.DEPTH(MAX_WINDOW), .DW(SB), .AW(AW)) u_sort (
		.clk, .ctl(sort_ctl), .waddr(sort_waddr), .wdata(sort_wdata),
		.raddr(sort_raddr), .rdata(sort_rdata)
	);

	// even count: middle pair averaged, rounded toward zero
	always_comb begin
		pair_sum = $signed({lo_q[SB-1], lo_q}) + $signed({hi_q[SB-1], hi_q});
		pair_adj = pair_sum + $signed({{SB{1'b0}}, pair_sum[SB]});
		median   = cnt_q[0] ? hi_q : pair_adj[SB:1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			len_q    <= swm_pkg::LEN_RESET;
			wp_q     <= '0;
			cnt_q    <= '0;
			sum_q    <= '0;
			idx_q    <= '0;
			ph_q     <= '0;
			found_q  <= 1'b0;
			ovalid_q <= 1'b0;
			v_q      <= '0;
			old_q    <= '0;
			hi_q     <= '0;
			lo_q     <= '0;
			min_q    <= '0;
			max_q    <= '0;
			odata_q  <= '0;
			ofull_q  <= 1'b0;
		end else begin
			if (out_load) begin
				ovalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				ovalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid && cfg_ready) begin
						len_q <= cfg_data;
						wp_q  <= '0;
						cnt_q <= '0;
						sum_q <= '0;
					end else if (in_acc) begin
						v_q   <= sample;
						sum_q <= sum_q + SUMW'($signed(sample));
						if (full_now) begin
							state_q <= ST_OLD;
						end else begin
							wp_q    <= wp_next;
							state_q <= ST_INS_START;
						end
					end
				end
				ST_OLD: begin
					old_q   <= ring_rdata;
					sum_q   <= sum_q - SUMW'($signed(ring_rdata));
					wp_q    <= wp_next;
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_RM_RD;
				end
				ST_RM_RD: begin
					state_q <= ST_RM_CHK;
				end
				ST_RM_CHK: begin
					if (!found_q && sort_rdata == old_q) begin
						found_q <= 1'b1;
					end
					if (idx_q + CW'(1) == cnt_q) begin
						cnt_q   <= cnt_q - CW'(1);
						state_q <= ST_INS_START;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= ST_RM_RD;
					end
				end
				ST_INS_START: begin
					if (cnt_q == '0) begin
						cnt_q   <= CW'(1);
						ph_q    <= '0;
						state_q <= ST_FIN;
					end else begin
						idx_q   <= cnt_q - CW'(1);
						state_q <= ST_INS_RD;
					end
				end
				ST_INS_RD: begin
					state_q <= ST_INS_CHK;
				end
				ST_INS_CHK: begin
					if ($signed(sort_rdata) > $signed(v_q)) begin
						if (idx_q == '0) begin
							state_q <= ST_INS_LAST;
						end else begin
							idx_q   <= idx_q - CW'(1);
							state_q <= ST_INS_RD;
						end
					end else begin
						cnt_q   <= cnt_q + CW'(1);
						ph_q    <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_INS_LAST: begin
					cnt_q   <= cnt_q + CW'(1);
					ph_q    <= '0;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					ph_q <= ph_q + 3'd1;
					case (ph_q)
						3'd1: hi_q  <= sort_rdata;
						3'd2: lo_q  <= sort_rdata;
						3'd3: min_q <= sort_rdata;
						3'd4: begin
							max_q   <= sort_rdata;
							state_q <= ST_OUT;
						end
						default: begin
						end
					endcase
				end
				ST_OUT: begin
					if (out_load) begin
						odata_q  <= OUT_W'({cnt_q, sum_q, max_q, min_q, median});
						ofull_q  <= (cnt_q == len_eff);
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid   = ovalid_q;
	assign m_axis_tdata    = odata_q;
	assign m_axis_tuser[0] = ofull_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= MAX_WINDOW)
		else $error("held count above window capacity");
	a_cfg_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (cnt_q == '0 && wp_q == '0))
		else $error("length write did not empty the window");
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		!(sort_ctl.we && sort_ctl.re && sort_waddr == sort_raddr))
		else $error("sorted RAM read and write hit the same entry");
	a_out_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (cnt_q != '0 && cnt_q <= len_eff))
		else $error("result count out of range");
`endif
endmodule
`default_nettype wire

// ===== verif/sliding_window_median_unit_test.sv =====
// Self-checking testbench for sliding_window_median_unit: streams samples through,
// predicts median/min/max/sum/count/full per word and compares. Needs swm_pkg.
`default_nettype none
module sliding_window_median_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_MAX     = 64;
	localparam int DRAIN_WAIT  = 300;    // settle time, longer than one word takes at full window
	localparam int STALL_LIMIT = 20000;  // cycles with work pending but no handshake

	// one result word, fields as the block reports them
	typedef struct packed {
		logic signed [15:0] median;
		logic signed [15:0] lowest;
		logic signed [15:0] highest;
		logic signed [21:0] total;
		logic [6:0]         held;
		logic               full;
	} window_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;        // [15:0] sample
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [79:0] m_axis_tdata;             // median, min, max, sum(22), count(7) from bit 0
	logic [0:0] m_axis_tuser;              // window_full
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [swm_pkg::LEN_W-1:0] cfg_data = '0;

	sliding_window_median_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// stimulus and expectation stores
	logic [15:0]   sample_queue[$];
	window_stats_t stats_queue[$];
	int send_idle = 0;     // percent of cycles the sender holds off
	int recv_idle = 0;     // percent of cycles the receiver stalls
	int errors = 0;
	bit word_taken = 0;    // set at rising edge, consumed by driver at falling edge
	bit cfg_taken = 0;

	// shadow of the window
	logic signed [15:0] ring[WIN_MAX];
	logic signed [15:0] ordered[$];
	int slot = 0;
	int length_reg = WIN_MAX;
	logic signed [21:0] run_sum = '0;

	function automatic int clamped_length();
		int l;
		l = length_reg;
		if (l == 0) l = 1;
		if (l > WIN_MAX) l = WIN_MAX;
		return l;
	endfunction

	// update the shadow window with one sample and queue the stats it yields
	task automatic track_sample(input logic signed [15:0] v);
		int len, n, i;
		logic signed [15:0] old;
		window_stats_t st;
		len = clamped_length();
		if (slot >= len) slot = 0;
		if (ordered.size() >= len) begin
			old = ring[slot];
			run_sum = run_sum - 22'(old);
			for (i = 0; i < ordered.size(); i++) begin
				if (ordered[i] == old) begin
					ordered.delete(i);
					break;
				end
			end
		end
		ring[slot] = v;
		slot++;
		if (slot >= len) slot = 0;
		run_sum = run_sum + 22'(v);
		i = 0;
		while (i < ordered.size() && ordered[i] <= v) i++;
		ordered.insert(i, v);
		n = ordered.size();
		// even count: mean of middle pair, division truncates toward zero
		if (n % 2) st.median = ordered[n/2];
		else st.median = 16'((int'(ordered[n/2-1]) + int'(ordered[n/2])) / 2);
		st.lowest  = ordered[0];
		st.highest = ordered[n-1];
		st.total   = run_sum;
		st.held    = 7'(n);
		st.full    = (n == len);
		stats_queue.push_back(st);
	endtask

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// driver: one nonblocking update per signal per falling edge
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || word_taken) begin
				word_taken = 0;
				if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
					s_axis_tdata  <= sample_queue.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// monitor: sample handshakes at the rising edge
	int stall_cycles = 0;
	always @(posedge clk) begin
		window_stats_t want, got;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				length_reg = int'(cfg_data);
				ordered.delete();
				slot = 0;
				run_sum = '0;
				cfg_taken = 1;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				track_sample(s_axis_tdata);
				word_taken = 1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.median  = m_axis_tdata[15:0];
				got.lowest  = m_axis_tdata[31:16];
				got.highest = m_axis_tdata[47:32];
				got.total   = m_axis_tdata[69:48];
				got.held    = m_axis_tdata[76:70];
				got.full    = m_axis_tuser[0];
				if (stats_queue.size() == 0) begin
					report("unexpected word", 0, 0);
				end else begin
					want = stats_queue.pop_front();
					if (got.median !== want.median) report("median", got.median, want.median);
					if (got.lowest !== want.lowest) report("minimum", got.lowest, want.lowest);
					if (got.highest !== want.highest)
						report("maximum", got.highest, want.highest);
					if (got.total !== want.total) report("sum", got.total, want.total);
					if (got.held !== want.held) report("count", got.held, want.held);
					if (got.full !== want.full) report("full", got.full, want.full);
				end
			end
			// watchdog
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) ||
				(sample_queue.size() == 0 && stats_queue.size() == 0 && !s_axis_tvalid &&
				 !cfg_valid))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("timeout with %0d words outstanding", stats_queue.size());
				$display("sliding_window_median_unit_test: FAIL");
				$finish;
			end
		end
	end

	// wait for every queued sample to come back, then let the block settle
	task automatic drain();
		while (sample_queue.size() > 0 || s_axis_tvalid || stats_queue.size() > 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(negedge clk);
	endtask

	task automatic set_length(input logic [6:0] len);
		drain();
		cfg_data  <= len;
		cfg_valid <= 1'b1;
		cfg_taken = 0;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// random sample: mostly full range, some narrow (duplicates), some extremes
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'($signed($urandom_range(8)) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic feed_random(input int count);
		repeat (count) sample_queue.push_back(pick_sample());
	endtask

	initial begin
		logic [15:0] edge_samples[];
		edge_samples = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h7fff,
			16'h7fff, 16'h8000, 16'h8000, 16'hfffd, 16'h0000, 16'h0001, 16'h0001,
			16'hfffe, 16'h0003, 16'h5555, 16'haaaa, 16'h0000, 16'hffff, 16'h0002,
			16'hfffb};
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// phase one: sender idles 36%, receiver 85%
		send_idle = 36; recv_idle = 85;
		foreach (edge_samples[i]) sample_queue.push_back(edge_samples[i]);
		set_length(7'd1);                  // single sample window
		feed_random(20);
		set_length(7'd0);                  // zero behaves as one
		feed_random(15);
		set_length(7'd2);                  // even pairs, truncation toward zero
		feed_random(30);
		set_length(7'd4);
		feed_random(30);

		// phase two: sender idles 85%, receiver 36%
		send_idle = 85; recv_idle = 36;
		set_length(7'd127);                // oversize clamps to the ring depth
		feed_random(80);
		set_length(7'd3);
		feed_random(30);
		set_length(7'(1 + $urandom_range(9)));
		feed_random(40);

		// phase three: no idling on either side
		send_idle = 0; recv_idle = 0;
		set_length(7'd64);
		feed_random(80);
		set_length(7'd5);
		feed_random(40);
		set_length(7'd64);                 // rewrite mid-run empties the window
		feed_random(20);
		set_length(7'd7);
		feed_random(40);
		drain();

		if (errors == 0)
			$display("sliding_window_median_unit_test: PASS");
		else
			$display("sliding_window_median_unit_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sliding_window_median_unit.f =====
design/swm_pkg.sv
design/swm_ram.sv
design/sliding_window_median_unit.sv
verif/sliding_window_median_unit_test.sv
